[sv/htil_pkg.sv]
// Shared types and constants for the hash table insert/lookup block.
// Item structs for both channels, op and status codes, FNV-1a constants.
// No dependencies.
package htil_pkg;

    localparam logic [31:0] FNV_OFFSET = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] key_name;
        logic [31:0] value_word;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic        was_found;
        logic [31:0] found_value;
        logic [7:0]  slot_index;
    } t_out_item;

endpackage

[sv/hash_table_insert_lookup_top.sv]
// Hash table insert/lookup block, top level.
// Depends on htil_pkg for item structs, op/status codes and FNV-1a constants.
//
// Open-addressed hash table with linear probing, one item at a time. The key is the
// 32-bit FNV-1a hash of the name (up to NAME_BYTES bytes, zero byte ends it), one byte
// per cycle through a single 32x32 multiplier. The start slot is the hash modulo
// TABLE_SLOTS: a mask for a power of two, otherwise a restoring reduction, 4 bits per step.
// Every slot lives in one synchronous single-port-read memory (used flag, name, value);
// each probe is a read plus a check. Clear sweeps the memory one slot a cycle. After
// reset the same sweep runs with the input stalled. A new item is taken while the
// previous result still waits.
module hash_table_insert_lookup_top
    import htil_pkg::*;
#(
    parameter int TABLE_SLOTS = 256,
    parameter int NAME_BYTES  = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int IDX_W   = $clog2(TABLE_SLOTS);
    localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
    localparam int NAME_W  = 8 * NAME_BYTES;
    localparam int LEN_W   = $clog2(NAME_BYTES + 1);
    localparam bit IS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);
    localparam logic [IDX_W:0]   SLOTS_W   = (IDX_W + 1)'(TABLE_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(TABLE_SLOTS - 2);

    typedef struct packed {
        logic              used;
        logic [NAME_W-1:0] name;
        logic [31:0]       value;
    } t_slot;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_RD,
        S_CHK,
        S_RESP
    } t_state;

    t_slot             mem [TABLE_SLOTS];
    t_slot             r_rd;

    t_state            r_state;
    logic [IDX_W-1:0]  r_ptr;
    logic              r_clr_resp;
    logic [CNT_W-1:0]  r_count;
    logic              r_ins;
    logic [NAME_W-1:0] r_name;
    logic [NAME_W-1:0] r_shift;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_byte;
    logic [31:0]       r_value;
    logic [31:0]       r_hash;
    logic [31:0]       r_mhash;
    logic [IDX_W-1:0]  r_rem;
    logic [2:0]        r_mcnt;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_probes;
    t_out_item         r_res;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic [NAME_W-1:0] n_name;
    logic [LEN_W-1:0]  n_len;
    logic [31:0]       n_hash;
    logic [IDX_W-1:0]  n_rem;
    logic [IDX_W-1:0]  n_idx;

    logic              w_en;
    logic [IDX_W-1:0]  w_addr;
    t_slot             w_data;

    logic              in_acc;
    logic              in_empty;
    logic              slot_free;
    logic              slot_hit;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;
    assign in_acc      = i_in_valid && !o_in_stall;

    // Name up to the first zero byte; later bytes are forced to zero.
    always_comb begin
        logic alive;
        alive  = 1'b1;
        n_name = '0;
        n_len  = '0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (alive && i_in_item.key_name[8*k +: 8] != 8'h00) begin
                n_name[8*k +: 8] = i_in_item.key_name[8*k +: 8];
                n_len            = LEN_W'(k + 1);
            end else begin
                alive = 1'b0;
            end
        end
    end

    // Empty name on insert or lookup, or zero value on insert.
    assign in_empty = (i_in_item.op == OP_INSERT || i_in_item.op == OP_LOOKUP)
        && (n_len == '0 || (i_in_item.op == OP_INSERT && i_in_item.value_word == '0));

    assign n_hash = (r_hash ^ {24'h0, r_shift[7:0]}) * FNV_PRIME;

    // Four restoring steps of hash mod TABLE_SLOTS, top bits first.
    always_comb begin
        logic [IDX_W:0] t;
        n_rem = r_rem;
        for (int k = 0; k < 4; k++) begin
            t = {n_rem, r_mhash[31-k]};
            if (t >= SLOTS_W) begin
                t = t - SLOTS_W;
            end
            n_rem = t[IDX_W-1:0];
        end
    end

    assign n_idx     = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
    assign slot_free = !r_rd.used;
    assign slot_hit  = r_rd.used && (r_rd.name == r_name);

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_idx;
        w_data = '{used: 1'b1, name: r_name, value: r_value};
        if (r_state == S_CLEAR) begin
            w_en   = 1'b1;
            w_addr = r_ptr;
            w_data = '{used: 1'b0, name: '0, value: '0};
        end else if (r_state == S_CHK && r_ins) begin
            w_en = slot_hit || (slot_free && r_count < FULL_CNT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd <= mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_ptr       <= '0;
            r_clr_resp  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // S_RESP drives the output register itself
            if (r_out_valid && !i_out_stall && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (r_ptr == LAST_IDX) begin
                        r_ptr <= '0;
                        r_state <= r_clr_resp ? S_RESP : S_IDLE;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_ins    <= (i_in_item.op == OP_INSERT);
                        r_name   <= n_name;
                        r_shift  <= n_name;
                        r_len    <= n_len;
                        r_byte   <= '0;
                        r_value  <= i_in_item.value_word;
                        r_hash   <= FNV_OFFSET;
                        r_res    <= '{status: in_empty ? ST_EMPTY : ST_OK, was_found: 1'b0,
                                      found_value: '0, slot_index: '0};
                        unique case (i_in_item.op)
                            OP_INSERT, OP_LOOKUP: begin
                                if (in_empty) begin
                                    r_state <= S_RESP;
                                end else begin
                                    r_state <= S_HASH;
                                end
                            end
                            OP_CLEAR: begin
                                r_count    <= '0;
                                r_clr_resp <= 1'b1;
                                r_ptr      <= '0;
                                r_state    <= S_CLEAR;
                            end
                            default: begin
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_HASH: begin
                    r_hash   <= n_hash;
                    r_shift  <= r_shift >> 8;
                    r_byte   <= r_byte + 1'b1;
                    r_probes <= '0;
                    if (r_byte + 1'b1 == r_len) begin
                        if (IS_POW2) begin
                            r_idx   <= n_hash[IDX_W-1:0];
                            r_state <= S_RD;
                        end else begin
                            r_mhash <= n_hash;
                            r_rem   <= '0;
                            r_mcnt  <= '0;
                            r_state <= S_MOD;
                        end
                    end
                end
                S_MOD: begin
                    r_rem   <= n_rem;
                    r_mhash <= r_mhash << 4;
                    r_mcnt  <= r_mcnt + 1'b1;
                    if (r_mcnt == 3'd7) begin
                        r_idx   <= n_rem;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (slot_hit) begin
                        r_res.was_found  <= 1'b1;
                        r_res.slot_index <= 8'(r_idx);
                        if (!r_ins) begin
                            r_res.found_value <= r_rd.value;
                        end
                        r_state <= S_RESP;
                    end else if (slot_free) begin
                        if (!r_ins) begin
                            r_res.status <= ST_NOT_FOUND;
                        end else if (r_count >= FULL_CNT) begin
                            r_res.status <= ST_FULL;
                        end else begin
                            r_count          <= r_count + 1'b1;
                            r_res.slot_index <= 8'(r_idx);
                        end
                        r_state <= S_RESP;
                    end else if (r_probes == LAST_IDX) begin
                        r_res.status <= r_ins ? ST_FULL : ST_NOT_FOUND;
                        r_state      <= S_RESP;
                    end else begin
                        r_probes <= r_probes + 1'b1;
                        r_idx    <= n_idx;
                        r_state  <= S_RD;
                    end
                end
                S_RESP: begin
                    r_clr_resp <= 1'b0;
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_item  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count above table limit");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en |-> (r_state == S_CLEAR || r_state == S_CHK))
        else $error("memory write outside clear or probe check");

    a_result_after_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK && (slot_hit || slot_free)) |=> r_state == S_RESP)
        else $error("probe end did not produce a result");

endmodule
